// File: rtl/dcc_pkg.sv
// Package for the debt cycle canceller: request/response types, state codes,
// DFS mark codes and balance limits. No dependencies.
`default_nettype none
package dcc_pkg;

  localparam int unsigned NodesDef = 16;
  localparam int unsigned MaxRsp   = 16;
  localparam logic signed [31:0] MinCap = 32'sd1000000000;
  localparam logic signed [33:0] BalMax = 34'sd2147483647;

  localparam logic [1:0] OpPost   = 2'd0;
  localparam logic [1:0] OpCancel = 2'd1;

  localparam logic [1:0] MkNew  = 2'd0;
  localparam logic [1:0] MkOpen = 2'd1;
  localparam logic [1:0] MkDone = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  first_node;
    logic [3:0]  second_node;
    logic [19:0] amount;
  } dcc_req_t;

  typedef struct packed {
    logic               status;
    logic [3:0]         from_node;
    logic [3:0]         to_node;
    logic signed [31:0] balance;
    logic               last;
  } dcc_rsp_t;

  typedef enum logic [14:0] {
    ST_CLR    = 15'b000000000000001,
    ST_IDLE   = 15'b000000000000010,
    ST_P_RAB  = 15'b000000000000100,
    ST_P_WAB  = 15'b000000000001000,
    ST_P_WBA  = 15'b000000000010000,
    ST_EMIT   = 15'b000000000100000,
    ST_C_ROOT = 15'b000000001000000,
    ST_C_RD   = 15'b000000010000000,
    ST_C_EV   = 15'b000000100000000,
    ST_C_COL  = 15'b000001000000000,
    ST_C_MRD  = 15'b000010000000000,
    ST_C_MEV  = 15'b000100000000000,
    ST_C_RAB  = 15'b001000000000000,
    ST_C_WAB  = 15'b010000000000000,
    ST_C_WBA  = 15'b100000000000000
  } dcc_state_e;

endpackage
`default_nettype wire

// File: rtl/dcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module dcc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: rtl/dcc_alu.sv
// Shared saturating adder and signed compare for balance updates.
// Depends on dcc_pkg.
`default_nettype none
module dcc_alu import dcc_pkg::*; (
  input  wire logic signed [31:0] opa_i,
  input  wire logic signed [32:0] opb_i,
  output logic signed [31:0]      sum_o,
  output logic                    lt_o
);
  logic signed [33:0] sum;

  assign sum  = {{2{opa_i[31]}}, opa_i} + {opb_i[32], opb_i};
  assign lt_o = $signed({opa_i[31], opa_i}) < opb_i;

  always_comb begin
    if (sum > BalMax) begin
      sum_o = BalMax[31:0];
    end else if (sum < -BalMax) begin
      sum_o = 32'(-BalMax);
    end else begin
      sum_o = sum[31:0];
    end
  end
endmodule
`default_nettype wire

// File: rtl/debt_cycle_canceller.sv
// Debt cycle canceller top: sequencer, balance RAM, shared saturating ALU.
// Read: RAB, WAB, EMIT; post adds WBA before EMIT, and EMIT waits while the output stalls.
// Cancel: DFS scan of the matrix, collect the cycle edges, find their minimum, then update
// each edge pair; only the first MaxRsp edges are reported.
// Reset: asynchronous; afterwards all 2^(2*ceil(log2 NODES)) RAM entries are cleared
// with in_ready_o low.
`default_nettype none
module debt_cycle_canceller import dcc_pkg::*; #(
  parameter int unsigned NODES = NodesDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire dcc_req_t in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output dcc_rsp_t      out_rsp_o
);
  localparam int unsigned NW    = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned AW    = 2 * NW;
  localparam int unsigned Depth = 1 << AW;

  dcc_state_e st_q, st_d, ret_q, ret_d;
  dcc_req_t   req_q, req_d;
  dcc_rsp_t   res_q, res_d, out_q, out_d;
  logic       out_valid_q, out_valid_d;
  logic [AW:0] clr_q, clr_d;
  logic [NW:0] root_q, root_d, u_q, u_d;
  logic [NW-1:0] v_q, v_d, head_q, head_d, x_q, x_d, n_q, n_d, rem_q, rem_d, a_q, a_d;
  logic signed [31:0] mn_q, mn_d, old_q, old_d;
  logic [4:0] cnt_q, cnt_d;

  logic [1:0]    mark_q [NODES];
  logic [NW-1:0] par_q  [NODES];
  logic [NW-1:0] rev_q  [NODES];
  logic          mark_clr, mark_we, par_we, rev_we;
  logic [NW-1:0] mark_idx;
  logic [1:0]    mark_val;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic signed [31:0] ram_wdata, ram_rdata, alu_sum;
  logic signed [32:0] alu_opb;
  logic          alu_lt;

  logic [NW-1:0] fa, fb, b_node;
  logic          emit_free;

  assign fa        = NW'(req_q.first_node);
  assign fb        = NW'(req_q.second_node);
  assign b_node    = (rem_q == '0) ? head_q : rev_q[rem_q - 1'b1];
  assign emit_free = !out_valid_q || out_ready_i;

  dcc_ram #(.Width(32), .Depth(Depth)) u_ram (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dcc_alu u_alu (
    .opa_i (ram_rdata),
    .opb_i (alu_opb),
    .sum_o (alu_sum),
    .lt_o  (alu_lt)
  );

  assign ram_wdata = (st_q == ST_CLR) ? '0 : alu_sum;

  always_comb begin
    st_d = st_q; ret_d = ret_q; req_d = req_q; res_d = res_q;
    clr_d = clr_q; root_d = root_q; u_d = u_q; v_d = v_q; head_d = head_q;
    x_d = x_q; n_d = n_q; rem_d = rem_q; a_d = a_q; mn_d = mn_q; old_d = old_q;
    cnt_d = cnt_q;
    out_d = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we = 1'b0; ram_waddr = '0; ram_raddr = '0; alu_opb = '0;
    mark_clr = 1'b0; mark_we = 1'b0; mark_idx = '0; mark_val = MkNew;
    par_we = 1'b0; rev_we = 1'b0;
    case (st_q)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q[AW-1:0];
        clr_d     = clr_q + 1'b1;
        if (clr_q == (AW+1)'(Depth - 1)) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d = in_req_i;
          ret_d = ST_IDLE;
          if (in_req_i.opcode == OpCancel) begin
            mark_clr = 1'b1;
            root_d   = '0;
            st_d     = ST_C_ROOT;
          end else if (32'(in_req_i.first_node) >= NODES ||
                       32'(in_req_i.second_node) >= NODES) begin
            res_d = '{status: 1'b0, from_node: in_req_i.first_node,
                      to_node: in_req_i.second_node, balance: '0, last: 1'b1};
            st_d  = ST_EMIT;
          end else begin
            st_d = ST_P_RAB;
          end
        end
      end
      ST_P_RAB: begin
        ram_raddr = {fa, fb};
        st_d      = ST_P_WAB;
      end
      ST_P_WAB: begin
        alu_opb   = -$signed({13'b0, req_q.amount});
        res_d     = '{status: 1'b0, from_node: req_q.first_node,
                      to_node: req_q.second_node, balance: ram_rdata, last: 1'b1};
        ram_raddr = {fb, fa};
        if (req_q.opcode == OpPost && fa != fb) begin
          ram_we        = 1'b1;
          ram_waddr     = {fa, fb};
          res_d.balance = alu_sum;
          st_d          = ST_P_WBA;
        end else begin
          st_d = ST_EMIT;
        end
      end
      ST_P_WBA: begin
        alu_opb   = $signed({13'b0, req_q.amount});
        ram_we    = 1'b1;
        ram_waddr = {fb, fa};
        st_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          st_d        = ret_q;
        end
      end
      ST_C_ROOT: begin
        if (root_q == (NW+1)'(NODES)) begin
          res_d = '{status: 1'b1, from_node: 4'd0, to_node: 4'd0, balance: '0, last: 1'b1};
          ret_d = ST_IDLE;
          st_d  = ST_EMIT;
        end else if (mark_q[root_q[NW-1:0]] != MkNew) begin
          root_d = root_q + 1'b1;
        end else begin
          v_d      = root_q[NW-1:0];
          u_d      = '0;
          mark_we  = 1'b1;
          mark_idx = root_q[NW-1:0];
          mark_val = MkOpen;
          st_d     = ST_C_RD;
        end
      end
      ST_C_RD: begin
        if (u_q == (NW+1)'(NODES)) begin
          mark_we  = 1'b1;
          mark_idx = v_q;
          mark_val = MkDone;
          if (v_q == root_q[NW-1:0]) begin
            root_d = root_q + 1'b1;
            st_d   = ST_C_ROOT;
          end else begin
            u_d = {1'b0, v_q} + 1'b1;
            v_d = par_q[v_q];
          end
        end else begin
          ram_raddr = {v_q, u_q[NW-1:0]};
          st_d      = ST_C_EV;
        end
      end
      ST_C_EV: begin
        st_d = ST_C_RD;
        u_d  = u_q + 1'b1;
        if (ram_rdata > 0) begin
          if (mark_q[u_q[NW-1:0]] == MkNew) begin
            par_we   = 1'b1;
            mark_we  = 1'b1;
            mark_idx = u_q[NW-1:0];
            mark_val = MkOpen;
            v_d      = u_q[NW-1:0];
            u_d      = '0;
          end else if (mark_q[u_q[NW-1:0]] == MkOpen) begin
            head_d = u_q[NW-1:0];
            x_d    = v_q;
            n_d    = '0;
            st_d   = ST_C_COL;
          end
        end
      end
      ST_C_COL: begin
        if (x_q == head_q) begin
          a_d   = head_q;
          rem_d = n_q;
          mn_d  = MinCap;
          st_d  = ST_C_MRD;
        end else begin
          rev_we = 1'b1;
          n_d    = n_q + 1'b1;
          x_d    = par_q[x_q];
        end
      end
      ST_C_MRD: begin
        ram_raddr = {a_q, b_node};
        st_d      = ST_C_MEV;
      end
      ST_C_MEV: begin
        alu_opb = {mn_q[31], mn_q};
        if (alu_lt) begin
          mn_d = ram_rdata;
        end
        if (rem_q == '0) begin
          a_d   = head_q;
          rem_d = n_q;
          cnt_d = '0;
          st_d  = ST_C_RAB;
        end else begin
          a_d   = b_node;
          rem_d = rem_q - 1'b1;
          st_d  = ST_C_MRD;
        end
      end
      ST_C_RAB: begin
        ram_raddr = {a_q, b_node};
        st_d      = ST_C_WAB;
      end
      ST_C_WAB: begin
        alu_opb   = -{mn_q[31], mn_q};
        old_d     = ram_rdata;
        ram_we    = 1'b1;
        ram_waddr = {a_q, b_node};
        ram_raddr = {b_node, a_q};
        st_d      = ST_C_WBA;
      end
      ST_C_WBA: begin
        alu_opb   = {mn_q[31], mn_q};
        ram_we    = 1'b1;
        ram_waddr = {b_node, a_q};
        a_d       = b_node;
        rem_d     = (rem_q == '0) ? rem_q : rem_q - 1'b1;
        ret_d     = (rem_q == '0) ? ST_IDLE : ST_C_RAB;
        if (cnt_q < 5'(MaxRsp)) begin
          res_d = '{status: 1'b0, from_node: 4'(a_q), to_node: 4'(b_node),
                    balance: old_q,
                    last: (rem_q == '0) || (cnt_q == 5'(MaxRsp - 1))};
          cnt_d = cnt_q + 1'b1;
          st_d  = ST_EMIT;
        end else begin
          st_d = (rem_q == '0) ? ST_IDLE : ST_C_RAB;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLR;
      ret_q       <= ST_IDLE;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      root_q      <= '0;
      cnt_q       <= '0;
      for (int i = 0; i < NODES; i++) begin
        mark_q[i] <= MkNew;
      end
    end else begin
      st_q        <= st_d;
      ret_q       <= ret_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      root_q      <= root_d;
      cnt_q       <= cnt_d;
      if (mark_clr) begin
        for (int i = 0; i < NODES; i++) begin
          mark_q[i] <= MkNew;
        end
      end else if (mark_we) begin
        mark_q[mark_idx] <= mark_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    res_q  <= res_d;
    out_q  <= out_d;
    u_q    <= u_d;
    v_q    <= v_d;
    head_q <= head_d;
    x_q    <= x_d;
    n_q    <= n_d;
    rem_q  <= rem_d;
    a_q    <= a_d;
    mn_q   <= mn_d;
    old_q  <= old_d;
    if (par_we) begin
      par_q[u_q[NW-1:0]] <= v_q;
    end
    if (rev_we) begin
      rev_q[n_q] <= x_q;
    end
  end

  assign in_ready_o  = (st_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTH
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_IDLE |-> !ram_we) else $error("RAM write while idle");
  a_eval_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_C_EV |-> $past(st_q) == ST_C_RD) else $error("scan eval without read");
  a_rsp_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 5'(MaxRsp)) else $error("too many cycle edges reported");
`endif

endmodule
`default_nettype wire

// File: sim/tb_top.sv
// Testbench for debt_cycle_canceller: random and directed post, cancel and read
// requests checked against a balance-matrix scoreboard. Depends on dcc_pkg.
`timescale 1ns / 1ps
module tb_top;
  import dcc_pkg::*;

  localparam int N = 16;
  localparam int CycleLimit = 1000000;
  localparam logic [1:0] OpRead = 2'd2;
  localparam logic [1:0] OpSpare = 2'd3;

  class balance_board;
    int signed owed[N][N];
    byte mark[N];
    int parent[N];
    int head, tail;
    dcc_rsp_t pending_q[$];
    int errors;

    function int signed clamp(longint v);
      if (v > 64'sd2147483647) return 2147483647;
      if (v < -64'sd2147483647) return -2147483647;
      return int'(v);
    endfunction

    function void push(bit st, int a, int b, int signed bal, bit lst);
      dcc_rsp_t r;
      r.status = st;
      r.from_node = a[3:0];
      r.to_node = b[3:0];
      r.balance = bal;
      r.last = lst;
      pending_q = {pending_q, r};
    endfunction

    function bit walk(int v);
      mark[v] = MkOpen;
      for (int u = 0; u < N; u++) begin
        if (owed[v][u] > 0) begin
          if (mark[u] == MkNew) begin
            parent[u] = v;
            if (walk(u)) return 1;
          end else if (mark[u] == MkOpen) begin
            head = u;
            tail = v;
            return 1;
          end
        end
      end
      mark[v] = MkDone;
      return 0;
    endfunction

    function void cancel_cycle();
      int path[$];
      int rev[$];
      int v, a, b, cnt;
      int signed mn, old;
      bit found;
      found = 0;
      mn = MinCap;
      for (int i = 0; i < N; i++) begin
        mark[i] = MkNew;
        parent[i] = -1;
      end
      for (v = 0; v < N && !found; v++)
        if (mark[v] == MkNew && walk(v)) found = 1;
      if (!found) begin
        push(1'b1, 0, 0, 0, 1'b1);
        return;
      end
      v = tail;
      while (v != head && v >= 0 && rev.size() < N) begin
        rev = {rev, v};
        v = parent[v];
      end
      path = {path, head};
      for (int i = rev.size() - 1; i >= 0; i--) path = {path, rev[i]};
      path = {path, head};
      for (int i = 0; i + 1 < path.size(); i++)
        if (owed[path[i]][path[i+1]] < mn) mn = owed[path[i]][path[i+1]];
      cnt = 0;
      for (int i = 0; i + 1 < path.size(); i++) begin
        a = path[i];
        b = path[i+1];
        old = owed[a][b];
        if (cnt < MaxRsp) begin
          push(1'b0, a, b, old, (i + 2 == path.size()) || (cnt == MaxRsp - 1));
          cnt++;
        end
        owed[a][b] = clamp(longint'(old) - mn);
        owed[b][a] = clamp(longint'(owed[b][a]) + mn);
      end
    endfunction

    function void note_request(dcc_req_t q);
      int a, b;
      a = q.first_node;
      b = q.second_node;
      if (q.opcode == OpCancel) begin
        cancel_cycle();
        return;
      end
      if (q.opcode == OpPost && a != b) begin
        owed[a][b] = clamp(longint'(owed[a][b]) - longint'(q.amount));
        owed[b][a] = clamp(longint'(owed[b][a]) + longint'(q.amount));
      end
      push(1'b0, a, b, owed[a][b], 1'b1);
    endfunction

    task report_mismatch(string what, dcc_rsp_t got, dcc_rsp_t want);
      $display("mismatch %s: got %p want %p", what, got, want);
      errors++;
    endtask

    task check_response(dcc_rsp_t got);
      dcc_rsp_t want;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected", got, got);
        return;
      end
      want = pending_q.pop_front();
      if (got.status !== want.status) report_mismatch("status", got, want);
      if (got.from_node !== want.from_node) report_mismatch("from_node", got, want);
      if (got.to_node !== want.to_node) report_mismatch("to_node", got, want);
      if (got.balance !== want.balance) report_mismatch("balance", got, want);
      if (got.last !== want.last) report_mismatch("last", got, want);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  dcc_req_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  dcc_rsp_t out_rsp_o;

  balance_board board = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;

  debt_cycle_canceller dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_req_i(in_req_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_rsp_o(out_rsp_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_response(out_rsp_o);
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_request(logic [1:0] op, int a, int b, int amt);
    dcc_req_t r;
    r.opcode = op;
    r.first_node = a[3:0];
    r.second_node = b[3:0];
    r.amount = amt[19:0];
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(r);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic random_request();
    int pick, a, b, amt;
    pick = $urandom_range(99);
    if ($urandom_range(9) < 8) begin
      a = $urandom_range(5);
      b = $urandom_range(5);
    end else begin
      a = $urandom_range(15);
      b = $urandom_range(15);
    end
    case ($urandom_range(3))
      0: amt = $urandom_range(1, 1000);
      1: amt = $urandom_range(20'hFFFFF);
      2: amt = 20'hFFFFF;
      default: amt = $urandom_range(1, 50000);
    endcase
    if (pick < 58) send_request(OpPost, a, b, amt);
    else if (pick < 80) send_request(OpCancel, a, b, amt);
    else if (pick < 95) send_request(OpRead, a, b, amt);
    else send_request(OpSpare, a, b, amt);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(OpRead, 15, 15, 0);
    send_request(OpRead, 0, 0, 20'hFFFFF);
    send_request(OpSpare, 3, 7, 0);
    send_request(OpPost, 9, 9, 20'hFFFFF);
    send_request(OpCancel, 0, 0, 0);
    send_request(OpPost, 15, 0, 20'hFFFFF);
    send_request(OpPost, 0, 15, 0);
    send_request(OpRead, 0, 15, 0);
    send_request(OpPost, 2, 1, 10);
    send_request(OpPost, 3, 2, 20);
    send_request(OpPost, 1, 3, 5);
    send_request(OpCancel, 15, 15, 20'hFFFFF);
    send_request(OpCancel, 0, 0, 0);
    for (int i = 0; i < 6; i++) send_request(OpPost, 4 + (i + 1) % 6, 4 + i, 300 + i);
    send_request(OpCancel, 0, 0, 0);
    send_request(OpRead, 9, 4, 0);
    send_request(OpCancel, 0, 0, 0);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 69 : (ph == 3) ? 31 : 0;
      stall_pct = (ph == 2) ? 69 : (ph == 3) ? 31 : 0;
      for (int k = 0; k < 63; k++) random_request();
    end
    in_valid_i <= 1'b0;

    wait (board.pending_q.size() == 0);
    repeat (50) @(posedge clk_i);
    if (board.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
